### rtl/xmcrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XMODEM-CRC receiver package
// Protocol characters, packet layout constants and the CRC-16 byte update.
// ----------------------------------------------------------------------------
package xmcrc_pkg;

   localparam int BLOCK_BYTES = 128;
   localparam int DATA_OFF_W  = $clog2(BLOCK_BYTES);
   localparam int PKT_OFF_W   = 8;
   localparam int CAP_W       = 11;
   localparam int ADDR_W      = 17;
   localparam int BLK_ADDR_W  = ADDR_W - DATA_OFF_W;

   // Offsets inside a packet, counted from the first byte after SOH
   localparam logic [PKT_OFF_W-1:0] OFF_DATA_FIRST = PKT_OFF_W'(2);
   localparam logic [PKT_OFF_W-1:0] OFF_CRC_HIGH   = PKT_OFF_W'(2 + BLOCK_BYTES);

   localparam logic [7:0] CH_SOH = 8'h01;
   localparam logic [7:0] CH_EOT = 8'h04;
   localparam logic [7:0] CH_ACK = 8'h06;
   localparam logic [7:0] CH_NAK = 8'h15;

   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

   localparam logic KIND_DATA  = 1'b0;
   localparam logic KIND_EVENT = 1'b1;

   // CRC-16/XMODEM, one byte, MSB first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc_cur,
                                            input logic [7:0]  data);
      logic [15:0] c;
      c = crc_cur ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

### rtl/xmodem_crc_block_receiver_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XMODEM-CRC block receiver
// Receiving side of XMODEM-CRC: stages data bytes with addresses, checks the
// CRC-16 and answers ACK/NAK, ends the session on EOT or a bad start byte.
// ----------------------------------------------------------------------------
// Feed received serial bytes one beat at a time on the req_ channel. While
// waiting for a frame, SOH opens a 132-byte packet (two block-number bytes
// that are not checked, 128 data bytes, CRC high, CRC low). Each data byte
// comes out on rsp_ as a staged write (tuser 0) with its target address,
// blocks accepted times 128 plus offset. After the CRC low byte one event beat
// (tuser 1) carries ACK with commit_block set when the CRC matches and the
// store still has room (blocks accepted below csr capacity), else NAK. EOT
// answers ACK and ends the session; any other start byte ends it with
// end_status 1 and no reply. Once the session ends, all bytes are dropped
// until reset. Block-number and CRC-high bytes produce no beat. Timing: every
// byte passes an input register and the CRC/decode logic into the output
// register, and one byte is taken every cycle as long as rsp_tready keeps the
// output register draining. Write csr_wr_data (block capacity, reset 256) only
// while no traffic is in flight; a new value applies at the next packet reply.
// ----------------------------------------------------------------------------
module xmodem_crc_block_receiver_unit import xmcrc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   // input byte stream
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,    // [7:0] rx_byte
   // result stream
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [31:0]      rsp_tdata,    // [7:0] out_byte, [24:8] byte_address,
                                          // [25] commit_block, [26] reply_valid,
                                          // [27] session_end, [28] end_status
   output logic [0:0]       rsp_tuser,    // [0] out_kind
   // configuration
   input  logic             csr_wr_en,
   input  logic [CAP_W-1:0] csr_wr_data   // capacity_blocks
);

   // Configuration register
   logic [CAP_W-1:0] capacity_ff;

   // Input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;

   // Receiver state
   logic                 in_packet_ff,  in_packet_in;
   logic                 sess_done_ff,  sess_done_in;
   logic [PKT_OFF_W-1:0] pkt_off_ff,    pkt_off_in;
   logic [15:0]          crc_ff,        crc_in;
   logic [7:0]           crc_high_ff,   crc_high_in;
   logic [CAP_W-1:0]     blocks_ff,     blocks_in;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kind_ff,  rsp_kind_in;
   logic [7:0]        rsp_byte_ff,  rsp_byte_in;
   logic [ADDR_W-1:0] rsp_addr_ff,  rsp_addr_in;
   logic              rsp_commit_ff, rsp_commit_in;
   logic              rsp_reply_ff,  rsp_reply_in;
   logic              rsp_end_ff,    rsp_end_in;
   logic              rsp_status_ff, rsp_status_in;

   logic                  out_free;
   logic                  proc_fire;
   logic                  req_fire;
   logic [PKT_OFF_W-1:0]  data_off;
   logic [15:0]           crc_got;

   // Output register can load when empty or being drained this cycle
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign proc_fire  = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || proc_fire;
   assign req_fire   = req_tvalid && req_tready;

   assign data_off = pkt_off_ff - OFF_DATA_FIRST;
   assign crc_got  = {crc_high_ff, in_byte_ff};

   always_comb begin
      in_packet_in  = in_packet_ff;
      sess_done_in  = sess_done_ff;
      pkt_off_in    = pkt_off_ff;
      crc_in        = crc_ff;
      crc_high_in   = crc_high_ff;
      blocks_in     = blocks_ff;

      rsp_valid_in  = 1'b0;
      rsp_kind_in   = KIND_DATA;
      rsp_byte_in   = 8'h00;
      rsp_addr_in   = '0;
      rsp_commit_in = 1'b0;
      rsp_reply_in  = 1'b0;
      rsp_end_in    = 1'b0;
      rsp_status_in = 1'b0;

      if (sess_done_ff) begin
         // drop everything until reset
      end else if (!in_packet_ff) begin
         if (in_byte_ff == CH_SOH) begin
            in_packet_in = 1'b1;
            pkt_off_in   = '0;
            crc_in       = '0;
            crc_high_in  = '0;
         end else begin
            sess_done_in = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_EVENT;
            rsp_end_in   = 1'b1;
            if (in_byte_ff == CH_EOT) begin
               rsp_byte_in  = CH_ACK;
               rsp_reply_in = 1'b1;
            end else begin
               rsp_status_in = 1'b1;
            end
         end
      end else begin
         pkt_off_in = pkt_off_ff + PKT_OFF_W'(1);
         if (pkt_off_ff < OFF_DATA_FIRST) begin
            // block number bytes: skip
         end else if (pkt_off_ff < OFF_CRC_HIGH) begin
            crc_in       = crc_byte(crc_ff, in_byte_ff);
            rsp_valid_in = 1'b1;
            rsp_byte_in  = in_byte_ff;
            rsp_addr_in  = {blocks_ff[BLK_ADDR_W-1:0], data_off[DATA_OFF_W-1:0]};
         end else if (pkt_off_ff == OFF_CRC_HIGH) begin
            crc_high_in = in_byte_ff;
         end else begin
            in_packet_in = 1'b0;
            pkt_off_in   = '0;
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_EVENT;
            rsp_reply_in = 1'b1;
            if ((crc_got == crc_ff) && (blocks_ff < capacity_ff)) begin
               blocks_in     = blocks_ff + CAP_W'(1);
               rsp_byte_in   = CH_ACK;
               rsp_commit_in = 1'b1;
            end else begin
               rsp_byte_in = CH_NAK;
            end
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAP_RESET;
         in_valid_ff  <= 1'b0;
         in_packet_ff <= 1'b0;
         sess_done_ff <= 1'b0;
         pkt_off_ff   <= '0;
         crc_ff       <= '0;
         crc_high_ff  <= '0;
         blocks_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         if (req_fire) begin
            in_valid_ff <= 1'b1;
         end else if (proc_fire) begin
            in_valid_ff <= 1'b0;
         end
         if (proc_fire) begin
            in_packet_ff <= in_packet_in;
            sess_done_ff <= sess_done_in;
            pkt_off_ff   <= pkt_off_in;
            crc_ff       <= crc_in;
            crc_high_ff  <= crc_high_in;
            blocks_ff    <= blocks_in;
         end
         if (out_free) begin
            rsp_valid_ff <= proc_fire && rsp_valid_in;
         end
      end
   end

   // Payload registers: hold until the next load
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_tdata;
      end
      if (proc_fire) begin
         rsp_kind_ff   <= rsp_kind_in;
         rsp_byte_ff   <= rsp_byte_in;
         rsp_addr_ff   <= rsp_addr_in;
         rsp_commit_ff <= rsp_commit_in;
         rsp_reply_ff  <= rsp_reply_in;
         rsp_end_ff    <= rsp_end_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {3'b000, rsp_status_ff, rsp_end_ff, rsp_reply_ff,
                        rsp_commit_ff, rsp_addr_ff, rsp_byte_ff};

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XMODEM-CRC block receiver testbench
// Streams whole packets of received bytes into the receiver and predicts every
// staged data beat and every ACK/NAK reply in step with the accepted input.
// Packets carry good and corrupted CRCs across several block capacities,
// including a store that is full and a capacity change in the middle of a
// packet. Both stream sides idle at random, and the result side holds off
// once for a long stretch. The session ends on EOT or on a bad start byte,
// and the bytes sent after that must be dropped.
// ----------------------------------------------------------------------------
module tb_top;
   import xmcrc_pkg::*;

   // SOH, two block-number bytes, the data block, CRC high and CRC low
   localparam int PKT_BEATS     = BLOCK_BYTES + 5;
   localparam int SETTLE_CYCLES = 8;      // well past the input and output registers
   localparam int HOLD_AT_BEAT  = 900;    // input beat count that starts the hold-off
   localparam int HOLD_CYCLES   = 300;
   localparam int REPORT_LIMIT  = 10;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;
   typedef enum int {FILL_RANDOM, FILL_EXTREMES} fill_style_type;

   // One result beat as the block should present it
   typedef struct packed {
      logic [2:0]        pad;
      logic              status;
      logic              sess_end;
      logic              reply;
      logic              commit;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data_byte;
      logic              kind;
   } rsp_beat_type;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_tvalid  = 1'b0;
   logic [7:0]       req_tdata   = 8'h00;
   logic             rsp_tready  = 1'b0;
   logic             csr_wr_en   = 1'b0;
   logic [CAP_W-1:0] csr_wr_data = '0;
   logic             req_tready;
   logic             rsp_tvalid;
   logic [31:0]      rsp_tdata;
   logic [0:0]       rsp_tuser;

   logic [7:0]     pending_bytes [$];     // bytes still to be offered on req_
   rsp_beat_type   expected_beats [$];    // predicted result beats, oldest first
   idle_mode_type  idle_mode  = IDLE_NONE;
   int             fail_count = 0;
   int             req_beats  = 0;
   int             hold_left  = 0;
   bit             hold_done  = 1'b0;

   // Receiver state as predicted from the accepted bytes
   logic [CAP_W-1:0] rx_capacity  = CAP_RESET;
   logic             rx_in_packet = 1'b0;
   logic [7:0]       rx_offset    = 8'h00;
   logic [15:0]      rx_crc       = 16'h0000;
   logic [7:0]       rx_crc_high  = 8'h00;
   logic [CAP_W-1:0] rx_blocks    = '0;
   logic             rx_done      = 1'b0;

   always #4 clock = ~clock;

   xmodem_crc_block_receiver_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // CRC-16/XMODEM, one data bit at a time from the MSB down
   function automatic logic [15:0] crc16_xmodem_step(input logic [15:0] crc,
                                                     input logic [7:0]  data);
      logic [15:0] acc;
      logic        fb;
      acc = crc;
      for (int i = 7; i >= 0; i--) begin
         fb  = acc[15] ^ data[i];
         acc = {acc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return acc;
   endfunction

   function automatic string beat_text(input rsp_beat_type b);
      return $sformatf({"kind=%0d byte=%h addr=%h commit=%0d reply=%0d ",
                        "end=%0d status=%0d pad=%0d"},
                       b.kind, b.data_byte, b.addr, b.commit, b.reply, b.sess_end,
                       b.status, b.pad);
   endfunction

   // Random gap decision for one side in the current idle phase
   function automatic bit gap_now(input bit sender_side);
      idle_mode_type own_mode;
      own_mode = sender_side ? IDLE_SENDER : IDLE_RECEIVER;
      if (idle_mode == own_mode) return $urandom_range(99) < 54;
      if (idle_mode == IDLE_BOTH) return $urandom_range(99) < 17;
      return 1'b0;
   endfunction

   // Advance the receiver prediction by one accepted byte and queue the beat
   // it causes, if any
   task automatic predict_rx_byte(input logic [7:0] b);
      rsp_beat_type beat;
      logic [7:0]   off;
      logic [15:0]  got;
      beat = '0;
      // once the session has ended every byte is dropped
      if (rx_done) return;
      if (!rx_in_packet) begin
         if (b == CH_SOH) begin
            rx_in_packet = 1'b1;
            rx_offset    = 8'h00;
            rx_crc       = 16'h0000;
            rx_crc_high  = 8'h00;
            return;
         end
         // EOT ends cleanly with ACK, any other start byte ends with an error
         rx_done       = 1'b1;
         beat.kind     = KIND_EVENT;
         beat.sess_end = 1'b1;
         if (b == CH_EOT) begin
            beat.data_byte = CH_ACK;
            beat.reply     = 1'b1;
         end else begin
            beat.status = 1'b1;
         end
         expected_beats.push_back(beat);
         return;
      end
      off       = rx_offset;
      rx_offset = off + 8'd1;
      // block-number bytes are not checked and give no beat
      if (off < OFF_DATA_FIRST) return;
      if (off < OFF_CRC_HIGH) begin
         rx_crc         = crc16_xmodem_step(rx_crc, b);
         beat.kind      = KIND_DATA;
         beat.data_byte = b;
         // address wraps at the 17-bit width
         beat.addr      = ADDR_W'(int'(rx_blocks) * BLOCK_BYTES + int'(off - OFF_DATA_FIRST));
         expected_beats.push_back(beat);
         return;
      end
      if (off == OFF_CRC_HIGH) begin
         rx_crc_high = b;
         return;
      end
      // CRC low byte closes the packet
      got          = {rx_crc_high, b};
      rx_in_packet = 1'b0;
      rx_offset    = 8'h00;
      beat.kind    = KIND_EVENT;
      beat.reply   = 1'b1;
      if (got == rx_crc && rx_blocks < rx_capacity) begin
         rx_blocks      = rx_blocks + 1'b1;
         beat.data_byte = CH_ACK;
         beat.commit    = 1'b1;
      end else begin
         // bad CRC or a full store
         beat.data_byte = CH_NAK;
      end
      expected_beats.push_back(beat);
   endtask

   // Input driver: offer the next pending byte once the current beat is taken
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_bytes.size() != 0 && !gap_now(1'b1)) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_bytes.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Long hold-off on the result side while the sender keeps offering bytes,
   // so the receiver pipeline fills up and drops req_tready
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && req_beats >= HOLD_AT_BEAT) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Result-side ready: random stalls per phase, forced low during the hold
   always @(posedge clock) begin
      rsp_tready <= (hold_left == 0) && !gap_now(1'b0);
   end

   // Monitor: check each result beat against the oldest prediction, then
   // predict from the byte accepted at this edge
   always @(posedge clock) begin : monitor_proc
      rsp_beat_type seen;
      rsp_beat_type wanted;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            seen.kind      = rsp_tuser[0];
            seen.data_byte = rsp_tdata[7:0];
            seen.addr      = rsp_tdata[24:8];
            seen.commit    = rsp_tdata[25];
            seen.reply     = rsp_tdata[26];
            seen.sess_end  = rsp_tdata[27];
            seen.status    = rsp_tdata[28];
            seen.pad       = rsp_tdata[31:29];
            if (expected_beats.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("ERROR: result beat with nothing expected: %s", beat_text(seen));
            end else begin
               wanted = expected_beats.pop_front();
               if (seen.kind !== wanted.kind || seen.data_byte !== wanted.data_byte ||
                   seen.addr !== wanted.addr || seen.commit !== wanted.commit ||
                   seen.reply !== wanted.reply || seen.sess_end !== wanted.sess_end ||
                   seen.status !== wanted.status || seen.pad !== wanted.pad) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT) begin
                     $display("ERROR: result beat mismatch at %0t", $realtime);
                     $display("   expected %s", beat_text(wanted));
                     $display("   actual   %s", beat_text(seen));
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predict_rx_byte(req_tdata);
            req_beats <= req_beats + 1;
         end
      end
   end

   // Wait until every byte is taken and every predicted beat has come out,
   // then let the pipeline settle for bytes that give no beat
   task automatic wait_until_idle();
      while (pending_bytes.size() != 0 || req_tvalid || expected_beats.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Single-cycle capacity write; only called with the block idle
   task automatic write_capacity(input logic [CAP_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      rx_capacity = value;
   endtask

   // Queue one packet; crc_flip corrupts the sent CRC, and a split_at inside
   // the packet pauses there to drain and write split_cap mid-packet
   task automatic send_packet(input fill_style_type style, input logic [15:0] crc_flip,
                              input int split_at, input logic [CAP_W-1:0] split_cap);
      logic [7:0]  pkt [PKT_BEATS];
      logic [7:0]  blk;
      logic [7:0]  data;
      logic [15:0] crc;
      blk    = 8'($urandom);
      crc    = 16'h0000;
      pkt[0] = CH_SOH;
      pkt[1] = blk;
      pkt[2] = ~blk;
      for (int i = 0; i < BLOCK_BYTES; i++) begin
         data = 8'($urandom);
         // open with the extreme values and the protocol characters
         if (style == FILL_EXTREMES && i < 16) begin
            case (i % 8)
               0: data = 8'h00;
               1: data = 8'hFF;
               2: data = CH_SOH;
               3: data = CH_EOT;
               4: data = CH_ACK;
               5: data = CH_NAK;
               6: data = 8'h80;
               default: data = 8'h7F;
            endcase
         end
         pkt[3 + i] = data;
         crc = crc16_xmodem_step(crc, data);
      end
      crc = crc ^ crc_flip;
      pkt[PKT_BEATS - 2] = crc[15:8];
      pkt[PKT_BEATS - 1] = crc[7:0];
      for (int i = 0; i < PKT_BEATS; i++) begin
         if (i == split_at) begin
            wait_until_idle();
            write_capacity(split_cap);
         end
         pending_bytes.push_back(pkt[i]);
      end
   endtask

   // One random phase: set capacity while idle, then packets that now and
   // then carry a corrupted CRC
   task automatic run_phase(input idle_mode_type mode, input logic [CAP_W-1:0] cap,
                            input int packets);
      logic [15:0] flip;
      wait_until_idle();
      write_capacity(cap);
      idle_mode = mode;
      repeat (packets) begin
         flip = ($urandom_range(99) < 15) ? 16'($urandom_range(65535, 1)) : 16'h0000;
         send_packet(FILL_RANDOM, flip, -1, '0);
      end
   endtask

   initial begin : stimulus_proc
      logic [7:0] last_byte;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset capacity, extreme data, then each CRC byte wrong
      idle_mode = IDLE_NONE;
      send_packet(FILL_EXTREMES, 16'h0000, -1, '0);
      send_packet(FILL_RANDOM, 16'h0001, -1, '0);
      send_packet(FILL_RANDOM, 16'h8000, -1, '0);
      // Zero capacity: a good packet must be refused
      wait_until_idle();
      write_capacity('0);
      send_packet(FILL_RANDOM, 16'h0000, -1, '0);
      // Widen to the largest 11-bit value in the middle of the data block;
      // the reply must already use it
      send_packet(FILL_RANDOM, 16'h0000, 70, CAP_W'(2047));

      // Random phases across idle patterns and capacities
      run_phase(IDLE_NONE, CAP_W'(1024), 1);
      run_phase(IDLE_SENDER, rx_blocks + 1'b1, 1);
      run_phase(IDLE_RECEIVER, CAP_W'($urandom_range(2047)), 1);
      run_phase(IDLE_BOTH, rx_blocks, 1);

      // Close the session with EOT or a stray start byte, then send bytes
      // that must be dropped
      wait_until_idle();
      idle_mode = IDLE_BOTH;
      if ($urandom_range(1) == 1) begin
         last_byte = CH_EOT;
      end else begin
         do last_byte = 8'($urandom);
         while (last_byte == CH_SOH || last_byte == CH_EOT);
      end
      pending_bytes.push_back(last_byte);
      repeat (8) pending_bytes.push_back(8'($urandom));

      wait_until_idle();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Run limit, far above the slowest correct run
   initial begin
      #2000000;
      $display("ERROR: run limit reached");
      $display("Test completed with failures");
      $finish;
   end

endmodule
